// ===== src/vln_pkg.sv =====
// Shared constants, types and helpers of the vector L2 normalizer.
package vln_pkg;

	localparam int MAX_DIM_DEF = 64;

	localparam int ELEM_W     = 16;
	localparam int LEN_W      = 7;
	localparam int SQ_W       = 31;
	localparam int SUM_W      = 37;
	localparam int QUO_W      = 32;
	localparam int ROOT_W     = 16;
	localparam int REM_W      = 18;
	localparam int DIV_STEPS  = 31;
	localparam int SQRT_STEPS = 16;
	localparam int ITER_W     = 5;
	localparam int CFG_IDX_W  = 1;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VECTOR_LENGTH    = 1'b0,
		REG_NORMALIZE_ENABLE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic acc_en;
		logic sum_clr;
		logic load;
		logic div_start;
		logic div_step;
		logic sqrt_step;
		logic out_load;
		logic out_last;
		logic pass;
	} ctrl_cmd_t;

	// Square of a Q4.12 element's magnitude; at most 2^30.
	function automatic logic [SQ_W-1:0] elem_square(input logic [ELEM_W-1:0] x);
		logic [ELEM_W-1:0]   mag;
		logic [2*ELEM_W-1:0] prod;
		mag  = x[ELEM_W-1] ? (~x + ELEM_W'(1)) : x;
		prod = mag * mag;
		return prod[SQ_W-1:0];
	endfunction

endpackage

// ===== src/vln_ram.sv =====
// Generic simple dual-port RAM with registered read.
module vln_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== src/vln_ctrl.sv =====
// Controller: collects a vector; per element: divide/root unless pass, then output.
module vln_ctrl import vln_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	localparam int AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             elem_valid,
	output logic             elem_ready,
	output logic             res_valid,
	input  logic             res_ready,
	input  logic [LEN_W-1:0] vector_length,
	input  logic             normalize_enable,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output logic [AW-1:0]    rd_addr,
	output ctrl_cmd_t        cmd
);

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_SQRT,
		ST_FINISH
	} state_t;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DIM);

	state_t            state_q;
	logic [AW-1:0]     count_q;
	logic [AW-1:0]     last_idx_q;
	logic [AW-1:0]     idx_q;
	logic [ITER_W-1:0] iter_q;
	logic              pass_q;
	logic              res_valid_q;

	logic             accept;
	logic [LEN_W-1:0] eff_len;
	logic [LEN_W:0]   cnt_next;
	logic             done;
	logic             can_load;
	logic             is_last;

	assign elem_ready = (state_q == ST_COLLECT);
	assign accept     = elem_valid && elem_ready;
	assign res_valid  = res_valid_q;
	assign wr_en      = accept;
	assign wr_addr    = count_q;
	assign rd_addr    = idx_q;

	always_comb begin
		if (vector_length == '0) begin
			eff_len = LEN_W'(1);
		end else if (vector_length > MAX_LEN) begin
			eff_len = MAX_LEN;
		end else begin
			eff_len = vector_length;
		end
	end

	assign cnt_next = (LEN_W+1)'(count_q) + (LEN_W+1)'(1);
	assign done     = (cnt_next >= {1'b0, eff_len});
	assign can_load = !res_valid_q || res_ready;
	assign is_last  = (idx_q == last_idx_q);

	always_comb begin
		cmd           = '0;
		cmd.pass      = pass_q;
		cmd.acc_en    = accept;
		cmd.load      = (state_q == ST_LOAD);
		cmd.div_start = (state_q == ST_DIV) && (iter_q == '0);
		cmd.div_step  = (state_q == ST_DIV) && (iter_q != '0);
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.out_load  = (state_q == ST_FINISH) && can_load;
		cmd.out_last  = is_last;
		cmd.sum_clr   = (state_q == ST_FINISH) && can_load && is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			count_q     <= '0;
			last_idx_q  <= '0;
			idx_q       <= '0;
			iter_q      <= '0;
			pass_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// Drop a taken result unless the output register reloads this cycle.
			if (res_valid_q && res_ready && (state_q != ST_FINISH)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_COLLECT: begin
					if (accept) begin
						if (done) begin
							last_idx_q <= count_q;
							count_q    <= '0;
							idx_q      <= '0;
							pass_q     <= !normalize_enable;
							state_q    <= ST_READ;
						end else begin
							count_q <= count_q + AW'(1);
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					iter_q  <= '0;
					state_q <= pass_q ? ST_FINISH : ST_DIV;
				end
				ST_DIV: begin
					if (iter_q == ITER_W'(DIV_STEPS - 1)) begin
						iter_q  <= '0;
						state_q <= ST_SQRT;
					end else begin
						iter_q <= iter_q + ITER_W'(1);
					end
				end
				ST_SQRT: begin
					if (iter_q == ITER_W'(SQRT_STEPS - 1)) begin
						iter_q  <= '0;
						state_q <= ST_FINISH;
					end else begin
						iter_q <= iter_q + ITER_W'(1);
					end
				end
				ST_FINISH: begin
					if (can_load) begin
						res_valid_q <= 1'b1;
						if (is_last) begin
							state_q <= ST_COLLECT;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

endmodule

// ===== src/vln_dp.sv =====
// Datapath: sum of squares, restoring divider, digit-serial square root, output register.
module vln_dp import vln_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	input  logic [ELEM_W-1:0] element_value,
	input  logic [ELEM_W-1:0] rd_data,
	output logic [ELEM_W-1:0] normalized_value,
	output logic              last_of_vector
);

	logic [SUM_W-1:0]  sum_q;
	logic [ELEM_W-1:0] x_s1;
	logic [SQ_W-1:0]   sq_s1;
	logic [SUM_W-1:0]  rem_div_q;
	logic [QUO_W-1:0]  quo_q;
	logic [REM_W-1:0]  rem_sq_q;
	logic [ROOT_W-1:0] root_q;
	logic [ELEM_W-1:0] out_val_q;
	logic              out_last_q;

	logic [SUM_W:0]    div_t;
	logic [SUM_W:0]    div_diff;
	logic              div_ge;
	logic [REM_W+1:0]  sq_t;
	logic [REM_W+1:0]  sq_trial;
	logic              sq_ge;
	logic [ELEM_W+2:0] pass_wide;
	logic [ELEM_W-1:0] pass_val;
	logic [ELEM_W-1:0] norm_val;

	// One quotient bit per step; the first step brings in the whole square.
	assign div_t    = cmd.div_start ? (SUM_W+1)'(sq_s1) : {rem_div_q, 1'b0};
	assign div_diff = div_t - {1'b0, sum_q};
	assign div_ge   = (div_t >= {1'b0, sum_q});

	// One root bit per step, two radicand bits shifted out of the quotient.
	assign sq_t     = {rem_sq_q, quo_q[QUO_W-1 -: 2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = (sq_t >= sq_trial);

	assign pass_wide = {x_s1, 3'b000};
	always_comb begin
		if ((pass_wide[ELEM_W+2:ELEM_W-1] == 4'b0000) ||
		    (pass_wide[ELEM_W+2:ELEM_W-1] == 4'b1111)) begin
			pass_val = pass_wide[ELEM_W-1:0];
		end else if (pass_wide[ELEM_W+2]) begin
			pass_val = {1'b1, {(ELEM_W-1){1'b0}}};
		end else begin
			pass_val = {1'b0, {(ELEM_W-1){1'b1}}};
		end
	end

	always_comb begin
		if (sum_q == '0) begin
			norm_val = '0;
		end else if (x_s1[ELEM_W-1]) begin
			norm_val = ~root_q + ROOT_W'(1);
		end else if (root_q[ROOT_W-1]) begin
			norm_val = {1'b0, {(ELEM_W-1){1'b1}}};
		end else begin
			norm_val = root_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.sum_clr) begin
			sum_q <= '0;
		end else if (cmd.acc_en) begin
			sum_q <= sum_q + SUM_W'(elem_square(element_value));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_s1  <= rd_data;
			sq_s1 <= elem_square(rd_data);
		end
		if (cmd.div_start || cmd.div_step) begin
			rem_div_q <= div_ge ? div_diff[SUM_W-1:0] : div_t[SUM_W-1:0];
			quo_q     <= cmd.div_start ? QUO_W'(div_ge) : {quo_q[QUO_W-2:0], div_ge};
		end else if (cmd.sqrt_step) begin
			quo_q <= {quo_q[QUO_W-3:0], 2'b00};
		end
		if (cmd.div_start) begin
			rem_sq_q <= '0;
			root_q   <= '0;
		end else if (cmd.sqrt_step) begin
			rem_sq_q <= sq_ge ? REM_W'(sq_t - sq_trial) : sq_t[REM_W-1:0];
			root_q   <= {root_q[ROOT_W-2:0], sq_ge};
		end
		if (cmd.out_load) begin
			out_val_q  <= cmd.pass ? pass_val : norm_val;
			out_last_q <= cmd.out_last;
		end
	end

	assign normalized_value = out_val_q;
	assign last_of_vector   = out_last_q;

endmodule

// ===== src/vector_l2_normalizer_top.sv =====
// Top level of the vector L2 normalizer: registers, element store, controller, datapath.
//
// Usage:
//   Elements (signed Q4.12) arrive on the elem_valid/elem_ready channel, one per
//   transaction, into the element store while their squares are summed. The element
//   that brings the count to vector_length (0 as 1, at most MAX_DIM) completes
//   the vector; the block then emits every stored element, scaled to unit L2
//   length as signed Q1.15, on res_valid/res_ready, with last_of_vector on the final one.
//   With normalize_enable low each element is emitted as X*8, saturated.
//   An all-zero vector emits zeros in normalize mode.
// Timing:
//   Collecting accepts one element per cycle. When normalizing, each element goes
//   through read, load, a 31-step restoring divide of X^2*2^30 by the sum, a
//   16-step digit-serial square root and output load; passing through has read,
//   load and output load. The shared divide/root unit handles one element at a time.
//   elem_ready stays low from the completing element until the last result of
//   the vector is loaded into the output register.
// Stall:
//   The output register holds a result while res_ready is low; computation of
//   the next element proceeds and waits at the output load.
// Reset:
//   arst_n clears the control state, the square sum and the registers
//   (vector_length 64, normalize_enable 1). The element store needs no clearing.
//   The configuration channel is always ready; write it only while idle.
module vector_l2_normalizer_top import vln_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 elem_valid,
	output logic                 elem_ready,
	input  logic [ELEM_W-1:0]    element_value,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [ELEM_W-1:0]    normalized_value,
	output logic                 last_of_vector,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data
);

	localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic [LEN_W-1:0] vector_length_q;
	logic             normalize_enable_q;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [ELEM_W-1:0] rd_data;
	ctrl_cmd_t         cmd;

	// Register writes complete in the cycle they are presented.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_length_q    <= LEN_RESET;
			normalize_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_VECTOR_LENGTH:    vector_length_q    <= cfg_data;
				REG_NORMALIZE_ENABLE: normalize_enable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Element store: written at the fill position, read at the emit position.
	vln_ram #(
		.WIDTH (ELEM_W),
		.DEPTH (MAX_DIM)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (element_value),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	vln_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.elem_valid       (elem_valid),
		.elem_ready       (elem_ready),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.vector_length    (vector_length_q),
		.normalize_enable (normalize_enable_q),
		.wr_en            (wr_en),
		.wr_addr          (wr_addr),
		.rd_addr          (rd_addr),
		.cmd              (cmd)
	);

	vln_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.element_value    (element_value),
		.rd_data          (rd_data),
		.normalized_value (normalized_value),
		.last_of_vector   (last_of_vector)
	);

endmodule

// ===== src/vln_checker.sv =====
// Port-level checks of the vector L2 normalizer, bound to the top level.
module vln_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        elem_valid,
	input logic        elem_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] normalized_value,
	input logic        last_of_vector
);

	// Hold a stalled result.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(normalized_value) &&
		$stable(last_of_vector))
		else $error("result changed while stalled");

	// Drop input acceptance while a vector is being emitted.
	a_no_input_mid_vector: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !last_of_vector |-> !elem_ready)
		else $error("input ready during vector emission");

	// A result never shows up in the cycle right after an element transaction.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		elem_valid && elem_ready |=> !$rose(res_valid))
		else $error("result appeared too early");

endmodule

bind vector_l2_normalizer_top vln_checker u_vln_checker (.*);
